// ===== src/hrhp_pkg.sv =====
// Shared types, codes and byte classification for the HTTP request head parser.
`default_nettype none
package hrhp_pkg;

  localparam int MAX_MESSAGE_BYTES_DEF = 65536;
  localparam int MAX_HEADERS_DEF       = 64;
  localparam int QUEUE_DEPTH           = 4;
  localparam int CAP_W                 = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [2:0] ST_NEED_MORE = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_TOO_MANY  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_METHOD  = 3'd1;
  localparam logic [2:0] KIND_URI     = 3'd2;
  localparam logic [2:0] KIND_VERSION = 3'd3;
  localparam logic [2:0] KIND_KEY     = 3'd4;
  localparam logic [2:0] KIND_VALUE   = 3'd5;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  field_kind;
    logic [15:0] field_start;
    logic [15:0] field_length;
    logic [5:0]  header_index;
  } out_beat_t;

  // Byte classes handed from the front end to the parser.
  typedef struct packed {
    logic restart;
    logic tchar;
    logic uri;
    logic sp;
    logic cr;
    logic lf;
    logic colon;
    logic digit;
    logic h;
    logic t;
    logic p;
    logic slash;
    logic one;
    logic dot;
  } cls_t;

  function automatic logic is_tchar(input logic [7:0] c);
    logic r;
    r = c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
                  8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
                  8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e};
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/http_request_head_parser.sv =====
// Top level of the HTTP/1 request head parser with its configuration register.
//
// Usage: bytes of a request head enter on in_valid/in_stall/in_data, one per beat;
// in_data.restart marks the first byte of a new message. Every input beat yields
// exactly one result beat on out_valid/out_stall/out_data carrying the sticky
// status and the span of any field that ends on that byte.
// Path: an accepted byte is written to the queue, then parsed into the result
// register, from which it is offered on out_data.
// Throughput: one byte per cycle while out_stall is low, set by the parser state update.
// A four-beat queue sits between the byte classifier and the parser, and the
// result register lets a new byte be parsed while an old result is being taken.
// When the receiver stalls, the result holds and the queue fills; in_stall rises
// once the queue is full. Reset (rst_n low, synchronous) empties the queue,
// drops the result, returns the parser to the start of a request line and sets
// header_capacity to 64. header_capacity sits at byte address 0 of the APB port
// and should be written only while the parser is idle.
`default_nettype none
module http_request_head_parser import hrhp_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF,
  parameter int MAX_HEADERS       = MAX_HEADERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_beat_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             cfg_wr;
  logic             q_valid;
  logic             q_pop;
  cls_t             q_data;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign cap_nxt = cfg_wr ? pwdata[CAP_W-1:0] : cap_r;
  assign prdata  = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  hrhp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  hrhp_back #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
    .MAX_HEADERS       (MAX_HEADERS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .header_capacity (cap_r),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

endmodule
`default_nettype wire

// ===== src/hrhp_front.sv =====
// Front end: classifies incoming bytes and queues them for the parser.
`default_nettype none
module hrhp_front import hrhp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_data,
  output logic          q_valid,
  output cls_t          q_data,
  input  wire logic     q_pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cls_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  cls_t          cls;
  logic          push;
  logic          pop;

  always_comb begin
    cls.restart = in_data.restart;
    cls.tchar   = is_tchar(in_data.data_byte);
    cls.uri     = (in_data.data_byte > CH_SP) && (in_data.data_byte != CH_DEL);
    cls.sp      = in_data.data_byte == CH_SP;
    cls.cr      = in_data.data_byte == CH_CR;
    cls.lf      = in_data.data_byte == CH_LF;
    cls.colon   = in_data.data_byte == CH_COLON;
    cls.digit   = in_data.data_byte inside {[8'h30:8'h39]};
    cls.h       = in_data.data_byte == CH_H;
    cls.t       = in_data.data_byte == CH_T;
    cls.p       = in_data.data_byte == CH_P;
    cls.slash   = in_data.data_byte == CH_SLASH;
    cls.one     = in_data.data_byte == CH_ONE;
    cls.dot     = in_data.data_byte == CH_DOT;
  end

  assign in_stall = cnt_r == CW'(QUEUE_DEPTH);
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != '0;
  assign pop      = q_pop && q_valid;
  assign q_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== src/hrhp_back.sv =====
// Back end: request head state machine, field spans and the result register.
`default_nettype none
module hrhp_back import hrhp_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF,
  parameter int MAX_HEADERS       = MAX_HEADERS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CAP_W-1:0] header_capacity,
  input  wire logic             q_valid,
  input  wire cls_t             q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_beat_t             out_data
);

  localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int HC_W  = $clog2(MAX_HEADERS + 1);
  localparam int CMP_W = (HC_W > CAP_W) ? HC_W : CAP_W;
  localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(MAX_MESSAGE_BYTES);
  localparam logic [CMP_W-1:0] HDR_LIMIT = CMP_W'(MAX_HEADERS);
  localparam logic [CMP_W-1:0] IDX_SAT   = CMP_W'(63);

  localparam logic [4:0] PH_M_FIRST    = 5'd0;
  localparam logic [4:0] PH_M_REST     = 5'd1;
  localparam logic [4:0] PH_SP1        = 5'd2;
  localparam logic [4:0] PH_URI        = 5'd3;
  localparam logic [4:0] PH_SP2        = 5'd4;
  localparam logic [4:0] PH_V_T1       = 5'd5;
  localparam logic [4:0] PH_V_T2       = 5'd6;
  localparam logic [4:0] PH_V_P        = 5'd7;
  localparam logic [4:0] PH_V_SLASH    = 5'd8;
  localparam logic [4:0] PH_V_ONE      = 5'd9;
  localparam logic [4:0] PH_V_DOT      = 5'd10;
  localparam logic [4:0] PH_V_DIG1     = 5'd11;
  localparam logic [4:0] PH_V_DIGS     = 5'd12;
  localparam logic [4:0] PH_RL_LF      = 5'd13;
  localparam logic [4:0] PH_LINE_START = 5'd14;
  localparam logic [4:0] PH_END_LF     = 5'd15;
  localparam logic [4:0] PH_KEY        = 5'd16;
  localparam logic [4:0] PH_KEY_SP     = 5'd17;
  localparam logic [4:0] PH_VAL_SKIP   = 5'd18;
  localparam logic [4:0] PH_VAL        = 5'd19;
  localparam logic [4:0] PH_VAL_CR     = 5'd20;

  logic [4:0]       phase_r, phase_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [15:0]      sb_r, sb_nxt;
  logic [15:0]      vte_r, vte_nxt;
  logic [HC_W-1:0]  hc_r, hc_nxt;
  logic [2:0]       fs_r, fs_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;

  logic [4:0]       ph;
  logic [OFF_W-1:0] offv;
  logic [15:0]      sbv;
  logic [15:0]      vtev;
  logic [HC_W-1:0]  hcv;
  logic [2:0]       fsv;
  logic [OFF_W+15:0] off_ext;
  logic [15:0]      off16;
  logic [CMP_W-1:0] hc_ext;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] capv;
  logic [5:0]       hidx_sat;
  logic             bad;
  logic             pop;
  cls_t             c;

  assign c     = q_data;
  assign pop   = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = pop;

  // A restart beat sees the cleared state instead of the stored one.
  always_comb begin
    ph       = c.restart ? PH_M_FIRST : phase_r;
    offv     = c.restart ? '0 : off_r;
    sbv      = c.restart ? '0 : sb_r;
    vtev     = c.restart ? '0 : vte_r;
    hcv      = c.restart ? '0 : hc_r;
    fsv      = c.restart ? ST_NEED_MORE : fs_r;
    off_ext  = {16'b0, offv};
    off16    = off_ext[15:0];
    hc_ext   = CMP_W'(hcv);
    cap_ext  = CMP_W'(header_capacity);
    capv     = (cap_ext > HDR_LIMIT) ? HDR_LIMIT : cap_ext;
    hidx_sat = (hc_ext > IDX_SAT) ? 6'd63 : hc_ext[5:0];
  end

  always_comb begin
    phase_nxt    = ph;
    off_nxt      = offv;
    sb_nxt       = sbv;
    vte_nxt      = vtev;
    hc_nxt       = hcv;
    fs_nxt       = fsv;
    bad          = 1'b0;
    out_data_nxt = '0;
    out_data_nxt.field_kind = KIND_NONE;
    if (fsv == ST_NEED_MORE) begin
      if (offv >= OFF_LIMIT) begin
        fs_nxt = ST_TOO_LONG;
      end else begin
        off_nxt = offv + OFF_W'(1);
        case (ph)
          PH_M_FIRST: begin
            if (c.tchar) begin
              sb_nxt    = off16;
              phase_nxt = PH_M_REST;
            end else begin
              bad = 1'b1;
            end
          end
          PH_M_REST: begin
            if (c.sp) begin
              out_data_nxt.field_kind   = KIND_METHOD;
              out_data_nxt.field_start  = sbv;
              out_data_nxt.field_length = off16 - sbv;
              phase_nxt = PH_SP1;
            end else if (!c.tchar) begin
              bad = 1'b1;
            end
          end
          PH_SP1: begin
            if (!c.sp) begin
              if (c.uri) begin
                sb_nxt    = off16;
                phase_nxt = PH_URI;
              end else begin
                bad = 1'b1;
              end
            end
          end
          PH_URI: begin
            if (c.sp) begin
              out_data_nxt.field_kind   = KIND_URI;
              out_data_nxt.field_start  = sbv;
              out_data_nxt.field_length = off16 - sbv;
              phase_nxt = PH_SP2;
            end else if (!c.uri) begin
              bad = 1'b1;
            end
          end
          PH_SP2: begin
            if (!c.sp) begin
              if (c.h) begin
                sb_nxt    = off16;
                phase_nxt = PH_V_T1;
              end else begin
                bad = 1'b1;
              end
            end
          end
          PH_V_T1: begin
            if (c.t) phase_nxt = PH_V_T2; else bad = 1'b1;
          end
          PH_V_T2: begin
            if (c.t) phase_nxt = PH_V_P; else bad = 1'b1;
          end
          PH_V_P: begin
            if (c.p) phase_nxt = PH_V_SLASH; else bad = 1'b1;
          end
          PH_V_SLASH: begin
            if (c.slash) phase_nxt = PH_V_ONE; else bad = 1'b1;
          end
          PH_V_ONE: begin
            if (c.one) phase_nxt = PH_V_DOT; else bad = 1'b1;
          end
          PH_V_DOT: begin
            if (c.dot) phase_nxt = PH_V_DIG1; else bad = 1'b1;
          end
          PH_V_DIG1: begin
            if (c.digit) phase_nxt = PH_V_DIGS; else bad = 1'b1;
          end
          PH_V_DIGS: begin
            if (c.cr) begin
              out_data_nxt.field_kind   = KIND_VERSION;
              out_data_nxt.field_start  = sbv;
              out_data_nxt.field_length = off16 - sbv;
              phase_nxt = PH_RL_LF;
            end else if (!c.digit) begin
              bad = 1'b1;
            end
          end
          PH_RL_LF: begin
            if (c.lf) phase_nxt = PH_LINE_START; else bad = 1'b1;
          end
          PH_LINE_START: begin
            if (c.cr) begin
              phase_nxt = PH_END_LF;
            end else if (c.tchar) begin
              sb_nxt    = off16;
              phase_nxt = PH_KEY;
            end else begin
              bad = 1'b1;
            end
          end
          PH_END_LF: begin
            if (c.lf) fs_nxt = ST_COMPLETE; else bad = 1'b1;
          end
          PH_KEY: begin
            if (c.sp || c.colon) begin
              out_data_nxt.field_kind   = KIND_KEY;
              out_data_nxt.field_start  = sbv;
              out_data_nxt.field_length = off16 - sbv;
              out_data_nxt.header_index = hidx_sat;
              phase_nxt = c.colon ? PH_VAL_SKIP : PH_KEY_SP;
            end else if (!c.tchar) begin
              bad = 1'b1;
            end
          end
          PH_KEY_SP: begin
            if (c.colon) begin
              phase_nxt = PH_VAL_SKIP;
            end else if (!c.sp) begin
              bad = 1'b1;
            end
          end
          PH_VAL_SKIP: begin
            if (!c.sp) begin
              sb_nxt = off16;
              if (c.cr) begin
                vte_nxt   = off16;
                phase_nxt = PH_VAL_CR;
              end else begin
                vte_nxt   = off16 + 16'd1;
                phase_nxt = PH_VAL;
              end
            end
          end
          PH_VAL: begin
            if (c.cr) begin
              phase_nxt = PH_VAL_CR;
            end else if (!c.sp) begin
              vte_nxt = off16 + 16'd1;
            end
          end
          PH_VAL_CR: begin
            if (c.lf) begin
              out_data_nxt.field_kind   = KIND_VALUE;
              out_data_nxt.field_start  = sbv;
              out_data_nxt.field_length = vtev - sbv;
              out_data_nxt.header_index = hidx_sat;
              if (hc_ext >= capv) begin
                fs_nxt = ST_TOO_MANY;
              end else begin
                hc_nxt = hcv + HC_W'(1);
              end
              phase_nxt = PH_LINE_START;
            end else begin
              // The held CR was value text after all.
              vte_nxt = off16;
              if (!c.cr) begin
                if (!c.sp) vte_nxt = off16 + 16'd1;
                phase_nxt = PH_VAL;
              end
            end
          end
          default: begin
            bad = 1'b1;
          end
        endcase
        if (bad) fs_nxt = ST_INVALID;
      end
    end
    out_data_nxt.status = fs_nxt;
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_M_FIRST;
      off_r       <= '0;
      sb_r        <= '0;
      vte_r       <= '0;
      hc_r        <= '0;
      fs_r        <= ST_NEED_MORE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        off_r   <= off_nxt;
        sb_r    <= sb_nxt;
        vte_r   <= vte_nxt;
        hc_r    <= hc_nxt;
        fs_r    <= fs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_none_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.field_kind == KIND_NONE) |->
      (out_data_r.field_start == 16'd0 && out_data_r.field_length == 16'd0 &&
       out_data_r.header_index == 6'd0))
    else $error("field without a kind carries a span");

  a_line_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.field_kind == KIND_METHOD ||
                     out_data_r.field_kind == KIND_URI ||
                     out_data_r.field_kind == KIND_VERSION)) |->
      out_data_r.header_index == 6'd0)
    else $error("request line field carries a header index");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !c.restart && fs_r != ST_NEED_MORE) |=>
      (out_data_r.field_kind == KIND_NONE && out_data_r.status == $past(fs_r)))
    else $error("final status did not hold");

  a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(hc_r) <= HDR_LIMIT)
    else $error("header count ran past its limit");

endmodule
`default_nettype wire
